// ----- design/btcr_pkg.sv -----
// ============================================================================
// btcr_pkg -- shared types and constants for the bitmap text console
// Holds the item structs, command codes, cursor constants and the 5x7 font.
// ============================================================================
package btcr_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [15:0] new_x;
        logic [15:0] new_y;
    } in_item_t;

    typedef struct packed {
        logic [25:0] row_address;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [9:0]  on_mask;
        logic        last;
    } out_item_t;

    // One character to draw, handed from the command decoder to the row emitter
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [5:0]  glyph;
    } glyph_job_t;

    typedef enum logic [1:0] {
        OP_PUT_CHAR   = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_HOME       = 2'd2
    } op_t;

    localparam logic [2:0] REG_ENABLED       = 3'd0;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [2:0] REG_PIXEL_BYTES   = 3'd4;

    localparam logic [7:0]  CHAR_NEWLINE  = 8'd10;
    localparam logic [15:0] HOME_POS      = 16'd12;
    localparam logic [4:0]  LINE_STEP     = 5'd20;
    localparam logic [4:0]  CELL_STEP     = 5'd12;
    localparam logic [4:0]  BOTTOM_MARGIN = 5'd16;
    localparam logic [3:0]  SCALED_ROWS   = 4'd14;

    // Add and clamp at the top of the 16-bit cursor range
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [4:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {12'd0, b};
            sat_add16 = s[16] ? 16'hFFFF : s[15:0];
        end
    endfunction

    // Fold lower case to upper case and map the code onto a font slot
    function automatic logic [5:0] font_index(input logic [7:0] code);
        logic [7:0] c;
        begin
            c = code;
            if (c inside {[8'd97:8'd122]})
                c = c - 8'd32;
            if (c inside {[8'd65:8'd90]})
                font_index = 6'(c - 8'd64);
            else if (c inside {[8'd48:8'd57]})
                font_index = 6'(c - 8'd48 + 8'd27);
            else
            begin
                case (c)
                    8'd45:   font_index = 6'd37;
                    8'd46:   font_index = 6'd38;
                    8'd58:   font_index = 6'd39;
                    8'd91:   font_index = 6'd40;
                    8'd93:   font_index = 6'd41;
                    8'd62:   font_index = 6'd42;
                    8'd47:   font_index = 6'd43;
                    default: font_index = 6'd0;
                endcase
            end
        end
    endfunction

    // Whole glyph, top row in the most significant five bits
    function automatic logic [34:0] font_glyph(input logic [5:0] idx);
        begin
            case (idx)
                6'd1:  font_glyph = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
                6'd2:  font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
                6'd3:  font_glyph = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
                6'd4:  font_glyph = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
                6'd5:  font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
                6'd6:  font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
                6'd7:  font_glyph = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
                6'd8:  font_glyph = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
                6'd9:  font_glyph = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
                6'd10: font_glyph = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
                6'd11: font_glyph = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
                6'd12: font_glyph = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
                6'd13: font_glyph = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
                6'd14: font_glyph = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
                6'd15: font_glyph = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
                6'd16: font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
                6'd17: font_glyph = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
                6'd18: font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
                6'd19: font_glyph = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
                6'd20: font_glyph = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
                6'd21: font_glyph = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
                6'd22: font_glyph = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
                6'd23: font_glyph = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
                6'd24: font_glyph = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
                6'd25: font_glyph = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
                6'd26: font_glyph = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
                6'd27: font_glyph = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
                6'd28: font_glyph = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
                6'd29: font_glyph = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
                6'd30: font_glyph = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
                6'd31: font_glyph = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
                6'd32: font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
                6'd33: font_glyph = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
                6'd34: font_glyph = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
                6'd35: font_glyph = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
                6'd36: font_glyph = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
                6'd37: font_glyph = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
                6'd38: font_glyph = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
                6'd39: font_glyph = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
                6'd40: font_glyph = {5'd14, 5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd14};
                6'd41: font_glyph = {5'd14, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd14};
                6'd42: font_glyph = {5'd16, 5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd16};
                6'd43: font_glyph = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
                default: font_glyph = 35'd0;
            endcase
        end
    endfunction

    // Pick one glyph row, row 0 at the top
    function automatic logic [4:0] font_row(input logic [5:0] idx, input logic [2:0] r);
        logic [34:0] g;
        begin
            g = font_glyph(idx);
            case (r)
                3'd0:    font_row = g[34:30];
                3'd1:    font_row = g[29:25];
                3'd2:    font_row = g[24:20];
                3'd3:    font_row = g[19:15];
                3'd4:    font_row = g[14:10];
                3'd5:    font_row = g[9:5];
                3'd6:    font_row = g[4:0];
                default: font_row = 5'd0;
            endcase
        end
    endfunction

    // Double each glyph column; leftmost glyph column lands on mask bits 0 and 1
    function automatic logic [9:0] scale_mask(input logic [4:0] bits);
        logic [9:0] m;
        begin
            m = 10'd0;
            for (int c = 0; c < 5; c++)
            begin
                m[2*c]   = bits[4-c];
                m[2*c+1] = bits[4-c];
            end
            scale_mask = m;
        end
    endfunction

endpackage

// ----- design/bitmap_text_console_renderer.sv -----
// ============================================================================
// bitmap_text_console_renderer -- 5x7 font text console at double scale
// Keeps a text cursor, decodes console commands and emits scaled glyph rows.
// ============================================================================
//
//  Channel | Signals                           | Transfer when
//  --------+-----------------------------------+-------------------------
//  in      | in_valid, in_ready, in_data       | in_valid && in_ready
//  out     | out_valid, out_ready, out_data    | out_valid && out_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | cfg_valid && cfg_ready
//          | cfg_data                          |
//
//  For a drawn character the row emitter walks the 14 scaled rows one per
//  cycle while out is not stalled, and the next character is taken in the
//  cycle its last row moves to the output register, so characters stream
//  back to back. Commands that draw nothing (cursor moves, newline, clipped
//  characters) only update the cursor; rows are registered before out.
//  Reset restores the register defaults and homes the cursor to (12,12).
//  A stall on out holds the output register and then backs up into in_ready.
//
module bitmap_text_console_renderer
    import btcr_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam logic [12:0] WIDTH_CAP  = 13'(MAX_WIDTH);
    localparam logic [12:0] HEIGHT_CAP = 13'(MAX_HEIGHT);

    // Configuration registers
    logic        enabled_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [14:0] line_stride_reg;
    logic [2:0]  pixel_bytes_reg;

    // Cursor
    logic [15:0] cursor_col_reg, cursor_col_next;
    logic [15:0] cursor_row_reg, cursor_row_next;

    logic        in_xfer;
    logic [12:0] width_eff;
    logic [12:0] height_eff;
    logic [2:0]  bpp;
    logic        wrap;
    logic [15:0] wrap_col;
    logic [15:0] wrap_row;
    logic        clipped;
    logic        draw;
    logic        job_ready;
    glyph_job_t  job;

    assign cfg_ready = 1'b1;
    assign in_ready  = job_ready;
    assign in_xfer   = in_valid && in_ready;

    // Clamp the screen size and pixel size to what the console supports
    assign width_eff  = (screen_width_reg  > WIDTH_CAP)  ? WIDTH_CAP  : screen_width_reg;
    assign height_eff = (screen_height_reg > HEIGHT_CAP) ? HEIGHT_CAP : screen_height_reg;
    assign bpp = (pixel_bytes_reg < 3'd2) ? 3'd2 :
                 ((pixel_bytes_reg > 3'd4) ? 3'd4 : pixel_bytes_reg);

    // Wrap to the next line when the cell would reach the right edge
    assign wrap     = ({1'b0, cursor_col_reg} + {12'd0, CELL_STEP}) >= {4'd0, width_eff};
    assign wrap_col = wrap ? HOME_POS : cursor_col_reg;
    assign wrap_row = wrap ? sat_add16(cursor_row_reg, LINE_STEP) : cursor_row_reg;

    // Drop the character when its line would reach the bottom edge
    assign clipped  = ({1'b0, wrap_row} + {12'd0, BOTTOM_MARGIN}) >= {4'd0, height_eff};

    assign draw = enabled_reg && (in_data.operation == OP_PUT_CHAR)
               && (in_data.char_code != CHAR_NEWLINE) && !clipped;

    assign job.row   = wrap_row[11:0];
    assign job.col   = wrap_col[11:0];
    assign job.glyph = font_index(in_data.char_code);

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (in_xfer && enabled_reg)
        begin
            case (in_data.operation)
                OP_SET_CURSOR:
                begin
                    cursor_col_next = in_data.new_x;
                    cursor_row_next = in_data.new_y;
                end
                OP_HOME:
                begin
                    cursor_col_next = HOME_POS;
                    cursor_row_next = HOME_POS;
                end
                OP_PUT_CHAR:
                begin
                    if (in_data.char_code == CHAR_NEWLINE)
                    begin
                        cursor_col_next = HOME_POS;
                        cursor_row_next = sat_add16(cursor_row_reg, LINE_STEP);
                    end
                    else
                    begin
                        // Wrap always sticks; advance only when the glyph is drawn
                        cursor_row_next = wrap_row;
                        cursor_col_next = clipped ? wrap_col : sat_add16(wrap_col, CELL_STEP);
                    end
                end
                default:
                begin
                    cursor_col_next = cursor_col_reg;
                    cursor_row_next = cursor_row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg       <= 1'b0;
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
            line_stride_reg   <= 15'd2560;
            pixel_bytes_reg   <= 3'd4;
            cursor_col_reg    <= HOME_POS;
            cursor_row_reg    <= HOME_POS;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENABLED:       enabled_reg       <= cfg_data[0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                    REG_LINE_STRIDE:   line_stride_reg   <= cfg_data;
                    REG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_data[2:0];
                    default:           enabled_reg       <= enabled_reg;
                endcase
            end
        end
    end

    // Walk the 14 scaled rows of each drawn character
    btcr_row_emitter u_row_emitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (in_xfer && draw),
        .job_ready   (job_ready),
        .job         (job),
        .line_stride (line_stride_reg),
        .bpp         (bpp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ----- design/btcr_row_emitter.sv -----
// ============================================================================
// btcr_row_emitter -- scaled glyph row generator
// Holds one glyph job and emits its 14 scaled rows through an output register.
// ============================================================================
module btcr_row_emitter
    import btcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  glyph_job_t  job,
    input  logic [14:0] line_stride,
    input  logic [2:0]  bpp,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic        job_valid_reg, job_valid_next;
    glyph_job_t  job_reg;
    logic [3:0]  k_reg, k_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic        load;
    logic        final_row;
    logic [11:0] y;
    logic [26:0] row_base;
    logic [14:0] col_offset;

    assign load      = job_valid_reg && (!out_valid_reg || out_ready);
    assign final_row = (k_reg == SCALED_ROWS - 4'd1);
    assign job_ready = !job_valid_reg || (load && final_row);

    assign y          = job_reg.row + {8'd0, k_reg};
    assign row_base   = y * line_stride;
    assign col_offset = job_reg.col * bpp;

    always_comb
    begin
        out_next.row_address = row_base[25:0] + {11'd0, col_offset};
        out_next.pixel_row   = y;
        out_next.pixel_col   = job_reg.col;
        out_next.on_mask     = scale_mask(font_row(job_reg.glyph, k_reg[3:1]));
        out_next.last        = final_row;
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        k_next         = k_reg;
        if (load)
        begin
            k_next = k_reg + 4'd1;
            if (final_row)
                job_valid_next = 1'b0;
        end
        if (job_valid && job_ready)
        begin
            job_valid_next = 1'b1;
            k_next         = 4'd0;
        end
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
            job_reg <= job;
        if (load)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
